// ===== src/xxh_pkg.sv =====
// xxh_pkg: shared types, constants and helpers for the xxh64 stream digest
// depends on nothing; used by xxh_front, xxh_back, the top level and the bench
`timescale 1ns / 1ps

package xxh_pkg;

	localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] P3 = 64'h165667B19E3779F9;
	localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

	localparam int unsigned STRIPE_BYTES = 32;
	localparam logic [3:0] MAX_WORD_BYTES = 4'd8;

	// one message word as it moves from front to back
	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        last;
	} xxh_word_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

endpackage

// ===== src/xxh_in_if.sv =====
// xxh_in_if: message word channel (valid, ready, word payload)
// depends on nothing
`timescale 1ns / 1ps

interface xxh_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last_word;

	modport source (output valid, output data_word, output byte_count, output last_word,
		input ready);
	modport sink (input valid, input data_word, input byte_count, input last_word,
		output ready);
endinterface

// ===== src/xxh_out_if.sv =====
// xxh_out_if: digest result channel (valid, ready, digest payload)
// depends on nothing
`timescale 1ns / 1ps

interface xxh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest;

	modport source (output valid, output digest, input ready);
	modport sink (input valid, input digest, output ready);
endinterface

// ===== src/xxh_front.sv =====
// xxh_front: accepts message words, clamps the byte count, queues them
// depends on xxh_pkg and xxh_in_if
`timescale 1ns / 1ps

module xxh_front (
	input  logic               clk,
	input  logic               arst_n,
	xxh_in_if.sink             in_ch,
	output logic               q_valid,
	output xxh_pkg::xxh_word_t q_word,
	input  logic               q_ready
);

	xxh_pkg::xxh_word_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	xxh_pkg::xxh_word_t in_word;

	always_comb begin
		in_word.data = in_ch.data_word;
		in_word.cnt  = (in_ch.byte_count > xxh_pkg::MAX_WORD_BYTES) ?
			xxh_pkg::MAX_WORD_BYTES : in_ch.byte_count;
		in_word.last = in_ch.last_word;
	end

	assign in_ch.ready = (count_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (count_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_word = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== src/xxh_mul.sv =====
// xxh_mul: 64x64 multiply keeping the low 64 bits, three 32x32 passes
// depends on nothing
`timescale 1ns / 1ps

module xxh_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] res
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] p0_q;
	logic [31:0] x_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	assign op_a = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
	assign op_b = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];
	assign prod = op_a * op_b;
	assign done = done_q;
	assign res  = p0_q + {x_q, 32'd0};

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (busy_q) begin
			case (step_q)
				2'd0: p0_q <= prod;
				2'd1: x_q <= prod[31:0];
				2'd2: x_q <= x_q + prod[31:0];
				default: x_q <= x_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= 2'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/xxh_back.sv =====
// xxh_back: stripe buffer, lane rounds, finish and avalanche sequencer
// depends on xxh_pkg, xxh_out_if and xxh_mul
`timescale 1ns / 1ps

module xxh_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [63:0]        cfg_wdata,
	input  logic               q_valid,
	input  xxh_pkg::xxh_word_t q_word,
	output logic               q_ready,
	xxh_out_if.source          out_ch
);

	typedef enum logic [4:0] {
		S_IDLE, S_INS, S_LR1, S_LR2, S_CONV, S_MG1, S_MG2, S_MG3, S_LEN, S_TAIL,
		S_T8A, S_T8B, S_T8C, S_T4A, S_T4B, S_T1A, S_T1B, S_AV1, S_AV2, S_EMIT
	} state_t;

	state_t       state_q;
	logic         wait_q;
	logic [1:0]   lane_q;
	logic [255:0] buf_q;
	logic [5:0]   fill_q;
	logic [63:0]  len_q;
	logic         started_q;
	logic [63:0]  acc_q [4];
	logic [63:0]  h_q;
	logic [63:0]  t_q;
	logic [63:0]  w_q;
	logic [3:0]   cnt_q;
	logic         last_q;
	logic [63:0]  seed_q;
	logic         o_valid_q;
	logic [63:0]  o_digest_q;

	logic         mul_state;
	logic         mul_start;
	logic [63:0]  mul_a;
	logic [63:0]  mul_b;
	logic         mul_done;
	logic [63:0]  m;
	logic [5:0]   space;
	logic [3:0]   k;
	logic [5:0]   new_fill;
	logic [255:0] ins_buf;
	logic [5:0]   idx;

	xxh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (m)
	);

	assign q_ready = (state_q == S_IDLE);
	assign out_ch.valid  = o_valid_q;
	assign out_ch.digest = o_digest_q;

	always_comb begin
		mul_state = 1'b1;
		mul_a = 64'd0;
		mul_b = xxh_pkg::P1;
		case (state_q)
			S_LR1: begin mul_a = buf_q[63:0]; mul_b = xxh_pkg::P2; end
			S_LR2: mul_a = xxh_pkg::rotl64(t_q, 31);
			S_MG1: begin mul_a = acc_q[0]; mul_b = xxh_pkg::P2; end
			S_MG2: mul_a = xxh_pkg::rotl64(t_q, 31);
			S_MG3: mul_a = h_q;
			S_T8A: begin mul_a = buf_q[63:0]; mul_b = xxh_pkg::P2; end
			S_T8B: mul_a = xxh_pkg::rotl64(t_q, 31);
			S_T8C: mul_a = xxh_pkg::rotl64(h_q, 27);
			S_T4A: mul_a = {32'd0, buf_q[31:0]};
			S_T4B: begin mul_a = xxh_pkg::rotl64(h_q, 23); mul_b = xxh_pkg::P2; end
			S_T1A: begin mul_a = {56'd0, buf_q[7:0]}; mul_b = xxh_pkg::P5; end
			S_T1B: mul_a = xxh_pkg::rotl64(h_q, 11);
			S_AV1: begin mul_a = h_q ^ (h_q >> 33); mul_b = xxh_pkg::P2; end
			S_AV2: begin mul_a = h_q ^ (h_q >> 29); mul_b = xxh_pkg::P3; end
			default: mul_state = 1'b0;
		endcase
		mul_start = mul_state && !wait_q;
	end

	// merge the pending word bytes into the stripe at the fill position
	always_comb begin
		space = 6'(xxh_pkg::STRIPE_BYTES) - fill_q;
		k = ({2'b00, cnt_q} < space) ? cnt_q : space[3:0];
		new_fill = fill_q + {2'b00, k};
		ins_buf = buf_q;
		idx = 6'd0;
		for (int j = 0; j < 32; j++) begin
			idx = 6'(j) - fill_q;
			if ((6'(j) >= fill_q) && (6'(j) < new_fill)) begin
				ins_buf[8*j +: 8] = w_q[{idx[2:0], 3'b000} +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				w_q    <= q_word.data;
				cnt_q  <= q_word.cnt;
				last_q <= q_word.last;
			end
			S_INS: begin
				buf_q <= ins_buf;
				w_q   <= w_q >> {k, 3'b000};
				cnt_q <= cnt_q - k;
				if (new_fill == 6'(xxh_pkg::STRIPE_BYTES) && !started_q) begin
					acc_q[0] <= seed_q + xxh_pkg::P1 + xxh_pkg::P2;
					acc_q[1] <= seed_q + xxh_pkg::P2;
					acc_q[2] <= seed_q;
					acc_q[3] <= seed_q - xxh_pkg::P1;
				end
			end
			S_CONV: begin
				if (started_q) begin
					h_q <= xxh_pkg::rotl64(acc_q[0], 1) + xxh_pkg::rotl64(acc_q[1], 7) +
						xxh_pkg::rotl64(acc_q[2], 12) + xxh_pkg::rotl64(acc_q[3], 18);
				end else begin
					h_q <= seed_q + xxh_pkg::P5;
				end
			end
			S_LEN: h_q <= h_q + len_q;
			default: begin
				if (wait_q && mul_done) begin
					case (state_q)
						S_LR1: t_q <= acc_q[0] + m;
						S_LR2: begin
							acc_q[0] <= acc_q[1];
							acc_q[1] <= acc_q[2];
							acc_q[2] <= acc_q[3];
							acc_q[3] <= m;
							buf_q    <= buf_q >> 64;
						end
						S_MG1, S_T8A: t_q <= m;
						S_MG2, S_T8B, S_T4A, S_T1A: h_q <= h_q ^ m;
						S_MG3: begin
							h_q      <= m + xxh_pkg::P4;
							acc_q[0] <= acc_q[1];
							acc_q[1] <= acc_q[2];
							acc_q[2] <= acc_q[3];
							acc_q[3] <= acc_q[0];
						end
						S_T8C: begin h_q <= m + xxh_pkg::P4; buf_q <= buf_q >> 64; end
						S_T4B: begin h_q <= m + xxh_pkg::P3; buf_q <= buf_q >> 32; end
						S_T1B: begin h_q <= m; buf_q <= buf_q >> 8; end
						default: h_q <= m;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wait_q     <= 1'b0;
			lane_q     <= 2'd0;
			fill_q     <= 6'd0;
			len_q      <= 64'd0;
			started_q  <= 1'b0;
			seed_q     <= 64'd0;
			o_valid_q  <= 1'b0;
			o_digest_q <= 64'd0;
		end else begin
			if (cfg_we) seed_q <= cfg_wdata;
			if (out_ch.valid && out_ch.ready) o_valid_q <= 1'b0;
			if (mul_start) wait_q <= 1'b1;
			else if (mul_done) wait_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						len_q   <= len_q + {60'd0, q_word.cnt};
						state_q <= S_INS;
					end
				end
				S_INS: begin
					fill_q <= new_fill;
					if (new_fill == 6'(xxh_pkg::STRIPE_BYTES)) begin
						started_q <= 1'b1;
						lane_q    <= 2'd0;
						state_q   <= S_LR1;
					end else if (last_q) begin
						state_q <= S_CONV;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_CONV: begin
					lane_q  <= 2'd0;
					state_q <= started_q ? S_MG1 : S_LEN;
				end
				S_LEN: state_q <= S_TAIL;
				S_TAIL: begin
					if (fill_q >= 6'd8) state_q <= S_T8A;
					else if (fill_q >= 6'd4) state_q <= S_T4A;
					else if (fill_q != 6'd0) state_q <= S_T1A;
					else state_q <= S_AV1;
				end
				S_EMIT: begin
					if (!o_valid_q) begin
						o_valid_q  <= 1'b1;
						o_digest_q <= h_q ^ (h_q >> 32);
						fill_q     <= 6'd0;
						len_q      <= 64'd0;
						started_q  <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					if (wait_q && mul_done) begin
						case (state_q)
							S_LR1: state_q <= S_LR2;
							S_LR2: begin
								lane_q <= lane_q + 2'd1;
								if (lane_q == 2'd3) begin
									fill_q  <= 6'd0;
									state_q <= S_INS;
								end else begin
									state_q <= S_LR1;
								end
							end
							S_MG1: state_q <= S_MG2;
							S_MG2: state_q <= S_MG3;
							S_MG3: begin
								lane_q  <= lane_q + 2'd1;
								state_q <= (lane_q == 2'd3) ? S_LEN : S_MG1;
							end
							S_T8A: state_q <= S_T8B;
							S_T8B: state_q <= S_T8C;
							S_T8C: begin fill_q <= fill_q - 6'd8; state_q <= S_TAIL; end
							S_T4A: state_q <= S_T4B;
							S_T4B: begin fill_q <= fill_q - 6'd4; state_q <= S_TAIL; end
							S_T1A: state_q <= S_T1B;
							S_T1B: begin fill_q <= fill_q - 6'd1; state_q <= S_TAIL; end
							S_AV1: state_q <= S_AV2;
							default: state_q <= S_EMIT;
						endcase
					end
				end
			endcase
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 6'(xxh_pkg::STRIPE_BYTES))
		else $error("stripe fill above stripe size");

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> wait_q)
		else $error("multiplier result without a pending request");

	a_lanes_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LR1 || state_q == S_LR2 || state_q == S_MG1) |-> started_q)
		else $error("lane round before lanes were seeded");

	a_tail_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_T1A) |-> (fill_q < 6'd4))
		else $error("single byte tail step with four or more bytes left");

endmodule

// ===== src/xxh64_stream_digest.sv =====
// xxh64_stream_digest: top level of the streaming 64-bit xxHash block
// depends on xxh_pkg, xxh_in_if, xxh_out_if, xxh_front and xxh_back
//
// in_ch carries message words (data_word, byte_count, last_word); a
// transaction completes when valid and ready are both high. byte_count
// above eight counts as eight. out_ch carries one digest per message,
// issued after the word marked last_word. cfg_we/cfg_wdata write the seed.
// A two-entry queue takes words while the back end works; a word that
// fills no stripe passes through the idle and insert states of the back
// end. Each completed 32-byte stripe adds four lane rounds of two
// multiplies plus one more insert pass, each multiply being three passes
// of one shared 32x32 multiplier. Finishing runs the lane merge (long
// messages only), the 8-byte tail pieces, the 4-byte piece, the tail
// bytes and the avalanche, besides the length add, the last tail check
// and the digest issue.
// Reset clears the stream state and the seed to zero. While a digest waits
// for out_ch ready the next message may start; a second digest holds in
// the back end until the first transaction completes.
`timescale 1ns / 1ps

module xxh64_stream_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	xxh_in_if.sink      in_ch,
	xxh_out_if.source   out_ch
);

	logic               q_valid;
	logic               q_ready;
	xxh_pkg::xxh_word_t q_word;

	xxh_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_word  (q_word),
		.q_ready (q_ready)
	);

	xxh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.q_ready   (q_ready),
		.out_ch    (out_ch)
	);

endmodule

// ===== tb/xxh64_stream_digest_tb.sv =====
// xxh64_stream_digest_tb: self-checking bench for the streaming xxh64 digest block
// depends on xxh_pkg, xxh_in_if, xxh_out_if and xxh64_stream_digest
`timescale 1ns / 1ps

module xxh64_stream_digest_tb;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 400;
	localparam int WORD_TARGET = 1450;

	// tracks the running hash state and the digests still owed by the block
	class digest_tracker;
		logic [63:0] seed;
		logic [63:0] lanes[4];
		logic [7:0]  stripe[32];
		int          fill;
		logic [63:0] total;
		bit          started;
		logic [63:0] expected_digests[$];
		int          errors;

		function new();
			seed = '0;
			fill = 0;
			total = '0;
			started = 0;
			errors = 0;
		endfunction

		function logic [63:0] rot(logic [63:0] x, int r);
			return (x << r) | (x >> (64 - r));
		endfunction

		function logic [63:0] mix(logic [63:0] acc, logic [63:0] lane);
			logic [63:0] a;
			a = acc + lane * xxh_pkg::P2;
			a = rot(a, 31);
			return a * xxh_pkg::P1;
		endfunction

		function logic [63:0] gather(int pos, int n);
			logic [63:0] v;
			v = '0;
			for (int i = 0; i < n; i++)
				v = v | ({56'b0, stripe[pos + i]} << (8 * i));
			return v;
		endfunction

		function void absorb_stripe();
			if (!started) begin
				lanes[0] = seed + xxh_pkg::P1 + xxh_pkg::P2;
				lanes[1] = seed + xxh_pkg::P2;
				lanes[2] = seed;
				lanes[3] = seed - xxh_pkg::P1;
				started = 1;
			end
			for (int i = 0; i < 4; i++)
				lanes[i] = mix(lanes[i], gather(8 * i, 8));
			fill = 0;
		endfunction

		function logic [63:0] final_digest();
			logic [63:0] h;
			int pos;
			pos = 0;
			if (started) begin
				h = rot(lanes[0], 1) + rot(lanes[1], 7) + rot(lanes[2], 12) + rot(lanes[3], 18);
				for (int i = 0; i < 4; i++) begin
					h = h ^ mix(64'd0, lanes[i]);
					h = h * xxh_pkg::P1 + xxh_pkg::P4;
				end
			end else begin
				h = seed + xxh_pkg::P5;
			end
			h = h + total;
			while (fill - pos >= 8) begin
				h = h ^ mix(64'd0, gather(pos, 8));
				h = rot(h, 27) * xxh_pkg::P1 + xxh_pkg::P4;
				pos += 8;
			end
			if (fill - pos >= 4) begin
				h = h ^ (gather(pos, 4) * xxh_pkg::P1);
				h = rot(h, 23) * xxh_pkg::P2 + xxh_pkg::P3;
				pos += 4;
			end
			while (pos < fill) begin
				h = h ^ ({56'b0, stripe[pos]} * xxh_pkg::P5);
				h = rot(h, 11) * xxh_pkg::P1;
				pos++;
			end
			h = h ^ (h >> 33);
			h = h * xxh_pkg::P2;
			h = h ^ (h >> 29);
			h = h * xxh_pkg::P3;
			h = h ^ (h >> 32);
			return h;
		endfunction

		function void note_word(logic [63:0] data, logic [3:0] cnt, logic last);
			int n;
			n = (cnt > 8) ? 8 : cnt;
			for (int i = 0; i < n; i++) begin
				stripe[fill] = data[8 * i +: 8];
				fill++;
				if (fill >= 32)
					absorb_stripe();
			end
			total = total + n;
			if (last) begin
				expected_digests.push_back(final_digest());
				fill = 0;
				total = '0;
				started = 0;
			end
		endfunction

		function void check_digest(logic [63:0] got);
			logic [63:0] want;
			if (expected_digests.size() == 0) begin
				$error("digest %h arrived with nothing expected", got);
				errors++;
				return;
			end
			want = expected_digests.pop_front();
			if (got !== want) begin
				$error("digest mismatch: expected %h actual %h", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_digests.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_wdata;

	xxh_in_if  in_ch();
	xxh_out_if out_ch();

	xxh64_stream_digest u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	digest_tracker tracker = new();

	int idle_cycles;
	int burst_left;
	int words_sent;
	int hold_requests;
	int holds_done;
	int hold_left;
	int rx_mode_left;
	bit rx_choppy;

	always #1 clk = ~clk;

	// receiver: alternates between always ready and random stalls, plus long hold-offs
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			tracker.check_digest(out_ch.digest);
		if (hold_requests != holds_done) begin
			holds_done = hold_requests;
			hold_left = 600;
		end
		if (rx_mode_left == 0) begin
			rx_mode_left = $urandom_range(50, 400);
			rx_choppy = 1'($urandom_range(0, 1));
		end else begin
			rx_mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= rx_choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.data_word <= data;
		in_ch.byte_count <= cnt;
		in_ch.last_word <= last;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		tracker.note_word(data, cnt, last);
		words_sent++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// message of n bytes in full words, last word carries the remainder
	task automatic send_bytes(int n);
		int left;
		left = n;
		if (n == 0) begin
			send_word(rand64(), 4'd0, 1'b1);
			return;
		end
		while (left > 0) begin
			send_word(rand64(), (left >= 8) ? 4'd8 : left[3:0], left <= 8);
			left -= 8;
		end
	endtask

	task automatic send_random_message();
		int nwords;
		int pick;
		logic [3:0] cnt;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			nwords = $urandom_range(1, 4);
		else if (pick < 95)
			nwords = $urandom_range(5, 12);
		else
			nwords = $urandom_range(20, 40);
		for (int i = 0; i < nwords; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				cnt = 4'd8;
			else if (pick < 9)
				cnt = 4'($urandom_range(0, 8));
			else
				cnt = 4'($urandom_range(9, 15));
			send_word(rand64(), cnt, i == nwords - 1);
		end
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.seed = value;
		@(posedge clk);
	endtask

	initial begin
		logic [63:0] seeds[6];
		clk = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		in_ch.valid = 0;
		in_ch.data_word = '0;
		in_ch.byte_count = '0;
		in_ch.last_word = 0;
		out_ch.ready = 0;
		idle_cycles = 0;
		burst_left = 0;
		words_sent = 0;
		hold_requests = 0;
		holds_done = 0;
		hold_left = 0;
		rx_mode_left = 0;
		rx_choppy = 0;
		seeds[0] = 64'd0;
		seeds[1] = '1;
		seeds[2] = rand64();
		seeds[3] = 64'd1;
		seeds[4] = 64'h8000_0000_0000_0000;
		seeds[5] = rand64();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, short tails, stripe edges, oversized and empty words
		send_bytes(0);
		send_word('0, 4'd1, 1'b1);
		send_word('1, 4'd8, 1'b1);
		send_word(64'h0123_4567_89ab_cdef, 4'd15, 1'b1);
		send_word('1, 4'd4, 1'b1);
		send_word('1, 4'd0, 1'b0);
		send_word(64'h5555_aaaa_5555_aaaa, 4'd9, 1'b0);
		send_word('1, 4'd0, 1'b1);
		send_bytes(31);
		send_bytes(32);
		send_bytes(33);
		send_bytes(36);
		send_bytes(63);
		send_word('1, 4'd8, 1'b0);
		send_word('1, 4'd8, 1'b0);
		send_word('1, 4'd8, 1'b0);
		send_word('1, 4'd8, 1'b0);
		send_word('0, 4'd0, 1'b1);

		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				wait_drained();
				write_seed(seeds[phase]);
			end
			// block fills up while the receiver is parked
			if (phase == 2)
				hold_requests++;
			while (words_sent < (phase + 1) * WORD_TARGET / 6)
				send_random_message();
		end

		wait_drained();
		if (tracker.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
